// ===== rtl/cnv_pkg.sv =====
// ----------------------------------------------------------------------------
// cnv_pkg
// Shared types, codes and helper functions for the card number validator.
// ----------------------------------------------------------------------------
package cnv_pkg;

    localparam int DEF_MIN_DIGITS = 13;
    localparam int DEF_MAX_DIGITS = 19;

    localparam logic [4:0] COUNT_SAT = 5'd31;

    // verdict codes
    localparam logic [1:0] VERDICT_VALID     = 2'd0;
    localparam logic [1:0] VERDICT_NON_DIGIT = 2'd1;
    localparam logic [1:0] VERDICT_BAD_LEN   = 2'd2;
    localparam logic [1:0] VERDICT_LUHN_FAIL = 2'd3;

    // card kind codes
    localparam logic [2:0] KIND_VISA   = 3'd0;
    localparam logic [2:0] KIND_MASTER = 3'd1;
    localparam logic [2:0] KIND_MAESTRO = 3'd2;
    localparam logic [2:0] KIND_AMEX   = 3'd3;
    localparam logic [2:0] KIND_JCB    = 3'd4;
    localparam logic [2:0] KIND_OTHER  = 3'd5;

    typedef struct packed {
        logic [4:0] digit_count;
        logic [3:0] sum_even_doubled;
        logic [3:0] sum_odd_doubled;
        logic       saw_non_digit;
        logic [3:0] first_digit;
        logic [3:0] second_digit;
    } t_card_state;

    function automatic logic [3:0] add_mod10(input logic [3:0] s, input logic [3:0] v);
        logic [4:0] t;
        t = {1'b0, s} + {1'b0, v};
        if (t >= 5'd10) begin
            t = t - 5'd10;
        end
        return t[3:0];
    endfunction

    function automatic logic [3:0] luhn_double(input logic [3:0] d);
        logic [4:0] t;
        t = {d, 1'b0};
        if (t > 5'd9) begin
            t = t - 5'd9;
        end
        return t[3:0];
    endfunction

    function automatic logic [2:0] kind_of(input logic [3:0] a, input logic [3:0] b);
        logic [2:0] k;
        case (a)
            4'd3: begin
                k = (b == 4'd4 || b == 4'd7) ? KIND_AMEX : KIND_JCB;
            end
            4'd4: k = KIND_VISA;
            4'd5: k = KIND_MASTER;
            4'd6: k = KIND_MAESTRO;
            default: k = KIND_OTHER;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/card_number_validator.sv =====
// ----------------------------------------------------------------------------
// card_number_validator
// Streaming Luhn mod-10 check and card kind detection, one character per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one ASCII character per item,
//   with i_last_char marking the final character of a card number. Blanks
//   (space, tab, LF, VT, FF, CR) are skipped; any other non-digit flags the
//   number. Output channel (o_valid / i_stall) carries one item per number:
//   o_verdict (non-digit, bad length, Luhn failure in that priority, else valid)
//   and o_card_kind from the leading two digits.
// Timing:
//   The block takes one item every cycle unless o_stall is high. A character
//   lands in an input register, and the state update plus the verdict logic fit
//   between that register and the result register, which captures the verdict
//   of a final character and drives o_valid.
// Stall:
//   While the result register holds an item that the receiver stalls, the
//   input register can still take one more character; o_stall rises only
//   when both registers are full and i_stall is high.
// Reset:
//   Synchronous, active low. Clears both valid flags and the running state,
//   so the next character starts a fresh number.
// ----------------------------------------------------------------------------
module card_number_validator #(
    parameter int MIN_DIGITS = cnv_pkg::DEF_MIN_DIGITS,
    parameter int MAX_DIGITS = cnv_pkg::DEF_MAX_DIGITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_verdict,
    output logic [2:0] o_card_kind
);
    import cnv_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_char_code;
    logic       r_last_char;

    // result register
    logic       r_out_valid;
    logic [1:0] r_verdict;
    logic [2:0] r_card_kind;

    logic        advance;
    logic        step;
    t_card_state next_state;
    logic [1:0]  n_verdict;
    logic [2:0]  n_card_kind;

    // Advance whenever the result register is free or being taken.
    assign advance = !r_out_valid || !i_stall;
    assign step    = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;

    cnv_accum u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_clear    (r_last_char),
        .i_char_code(r_char_code),
        .o_next     (next_state)
    );

    cnv_verdict #(
        .MIN_DIGITS(MIN_DIGITS),
        .MAX_DIGITS(MAX_DIGITS)
    ) u_verdict (
        .i_state    (next_state),
        .o_verdict  (n_verdict),
        .o_card_kind(n_card_kind)
    );

    // Load a new character whenever the input register is empty or moving on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_char_code <= i_char_code;
            r_last_char <= i_last_char;
        end
    end

    // Only a final character produces a result item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && r_last_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_last_char) begin
            r_verdict   <= n_verdict;
            r_card_kind <= n_card_kind;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_verdict   = r_verdict;
    assign o_card_kind = r_card_kind;

endmodule

// ===== rtl/cnv_accum.sv =====
// ----------------------------------------------------------------------------
// cnv_accum
// Running per-number state: digit count, both Luhn sums, non-digit flag and
// the two leading digits. Offers the state as updated by the current item.
// ----------------------------------------------------------------------------
module cnv_accum (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_clear,
    input  logic [7:0]           i_char_code,
    output cnv_pkg::t_card_state o_next
);
    import cnv_pkg::*;

    t_card_state r_state;
    t_card_state n_state;

    logic       blank;
    logic       is_digit;
    logic [3:0] dval;

    assign blank    = (i_char_code == 8'h20) ||
                      (i_char_code >= 8'h09 && i_char_code <= 8'h0D);
    assign is_digit = (i_char_code >= 8'h30 && i_char_code <= 8'h39);
    assign dval     = i_char_code[3:0];

    always_comb begin
        n_state = r_state;
        if (!blank) begin
            if (is_digit) begin
                if (r_state.digit_count == 5'd0) begin
                    n_state.first_digit = dval;
                end else if (r_state.digit_count == 5'd1) begin
                    n_state.second_digit = dval;
                end
                if (!r_state.digit_count[0]) begin
                    n_state.sum_even_doubled =
                        add_mod10(r_state.sum_even_doubled, luhn_double(dval));
                    n_state.sum_odd_doubled = add_mod10(r_state.sum_odd_doubled, dval);
                end else begin
                    n_state.sum_even_doubled = add_mod10(r_state.sum_even_doubled, dval);
                    n_state.sum_odd_doubled =
                        add_mod10(r_state.sum_odd_doubled, luhn_double(dval));
                end
                if (r_state.digit_count != COUNT_SAT) begin
                    n_state.digit_count = r_state.digit_count + 5'd1;
                end
            end else begin
                n_state.saw_non_digit = 1'b1;
            end
        end
    end

    assign o_next = n_state;

    // Drop the state after the final item of a number.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_step) begin
            r_state <= i_clear ? '0 : n_state;
        end
    end

endmodule

// ===== rtl/cnv_verdict.sv =====
// ----------------------------------------------------------------------------
// cnv_verdict
// Final decision for one number: verdict in priority order and card kind.
// ----------------------------------------------------------------------------
module cnv_verdict #(
    parameter int MIN_DIGITS = cnv_pkg::DEF_MIN_DIGITS,
    parameter int MAX_DIGITS = cnv_pkg::DEF_MAX_DIGITS
) (
    input  cnv_pkg::t_card_state i_state,
    output logic [1:0]           o_verdict,
    output logic [2:0]           o_card_kind
);
    import cnv_pkg::*;

    localparam logic [4:0] MinCnt = 5'(MIN_DIGITS);
    localparam logic [4:0] MaxCnt = 5'(MAX_DIGITS);

    logic [3:0] sel_sum;

    assign sel_sum = i_state.digit_count[0] ? i_state.sum_odd_doubled
                                            : i_state.sum_even_doubled;

    always_comb begin
        if (i_state.saw_non_digit) begin
            o_verdict = VERDICT_NON_DIGIT;
        end else if (i_state.digit_count < MinCnt || i_state.digit_count > MaxCnt) begin
            o_verdict = VERDICT_BAD_LEN;
        end else if (sel_sum != 4'd0) begin
            o_verdict = VERDICT_LUHN_FAIL;
        end else begin
            o_verdict = VERDICT_VALID;
        end
    end

    assign o_card_kind = kind_of(i_state.first_digit, i_state.second_digit);

endmodule

// ===== rtl/cnv_checker.sv =====
// ----------------------------------------------------------------------------
// cnv_checker
// Port-level checks for the card number validator, bound to the top level.
// ----------------------------------------------------------------------------
module cnv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       i_last_char,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_verdict,
    input logic [2:0] o_card_kind
);
    import cnv_pkg::*;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_verdict) && $stable(o_card_kind))
        else $error("result changed while stalled");

    // Back-pressure only when the result side is full and stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a stalled result");

    // A fresh result comes from a final character accepted at the edge
    // before the one that raised o_valid.
    a_rise_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall && i_last_char, 2))
        else $error("result without a final character");

    // Reset empties the block.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("block not empty after reset");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_card_kind <= KIND_OTHER)
        else $error("card kind out of range");

endmodule

bind card_number_validator cnv_checker u_cnv_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .i_last_char(i_last_char),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_verdict  (o_verdict),
    .o_card_kind(o_card_kind)
);

// ===== sim/tb_card_number_validator.sv =====
// ----------------------------------------------------------------------------
// tb_card_number_validator
// Self-checking bench for the streaming card number validator: it feeds text
// one character per item, predicts each verdict and card kind, and checks the
// results in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_card_number_validator;
    timeunit 1ns;
    timeprecision 1ps;

    import cnv_pkg::*;

    typedef logic [7:0] char_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic [2:0] kind;
    } card_result_t;

    // Scoreboard: tracks one number in flight and queues the verdict and card kind it predicts.
    class card_luhn_scoreboard;
        logic [4:0]   digits       = '0;
        logic [3:0]   sum_even_dbl = '0;
        logic [3:0]   sum_odd_dbl  = '0;
        logic         bad_char     = 1'b0;
        logic [3:0]   lead0        = '0;
        logic [3:0]   lead1        = '0;
        card_result_t expected_q[$];
        int           errors       = 0;

        task report_mismatch(input string msg);
            errors++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        function void clear_number();
            digits       = '0;
            sum_even_dbl = '0;
            sum_odd_dbl  = '0;
            bad_char     = 1'b0;
            lead0        = '0;
            lead1        = '0;
        endfunction

        function logic [2:0] kind_from_lead();
            logic [2:0] k;
            case (lead0)
                4'd3: k = (lead1 == 4'd4 || lead1 == 4'd7) ? KIND_AMEX : KIND_JCB;
                4'd4: k = KIND_VISA;
                4'd5: k = KIND_MASTER;
                4'd6: k = KIND_MAESTRO;
                default: k = KIND_OTHER;
            endcase
            return k;
        endfunction

        task note_char(input char_t ch, input logic fin);
            int           d;
            int           twice;
            logic [3:0]   picked;
            card_result_t r;
            if (!(ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D))) begin
                if (ch >= 8'h30 && ch <= 8'h39) begin
                    d = int'(ch) - 8'h30;
                    twice = 2 * d;
                    if (twice > 9) begin
                        twice -= 9;
                    end
                    if (digits == 5'd0) begin
                        lead0 = d[3:0];
                    end else if (digits == 5'd1) begin
                        lead1 = d[3:0];
                    end
                    if (!digits[0]) begin
                        sum_even_dbl = 4'((int'(sum_even_dbl) + twice) % 10);
                        sum_odd_dbl  = 4'((int'(sum_odd_dbl) + d) % 10);
                    end else begin
                        sum_even_dbl = 4'((int'(sum_even_dbl) + d) % 10);
                        sum_odd_dbl  = 4'((int'(sum_odd_dbl) + twice) % 10);
                    end
                    if (digits != 5'd31) begin
                        digits++;
                    end
                end else begin
                    bad_char = 1'b1;
                end
            end
            if (fin) begin
                picked = digits[0] ? sum_odd_dbl : sum_even_dbl;
                if (bad_char) begin
                    r.verdict = VERDICT_NON_DIGIT;
                end else if (digits < DEF_MIN_DIGITS || digits > DEF_MAX_DIGITS) begin
                    r.verdict = VERDICT_BAD_LEN;
                end else if (picked != 4'd0) begin
                    r.verdict = VERDICT_LUHN_FAIL;
                end else begin
                    r.verdict = VERDICT_VALID;
                end
                r.kind = kind_from_lead();
                expected_q.push_back(r);
                clear_number();
            end
        endtask

        task check_result(input logic [1:0] v, input logic [2:0] k);
            card_result_t want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: verdict=%0d kind=%0d",
                                          v, k));
                return;
            end
            want = expected_q.pop_front();
            if (v !== want.verdict) begin
                report_mismatch($sformatf("verdict got %0d want %0d", v, want.verdict));
            end
            if (k !== want.kind) begin
                report_mismatch($sformatf("card kind got %0d want %0d", k, want.kind));
            end
        endtask
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_char_code = 8'h00;
    logic       i_last_char = 1'b0;
    logic       i_stall     = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [1:0] o_verdict;
    logic [2:0] o_card_kind;

    card_luhn_scoreboard sb = new;

    // Shared knobs between the stimulus and the receiver.
    bit    quiet           = 1'b0;  // suppress random idling on both sides
    int    hold_off_cycles = 0;     // pending receiver hold-off, counted down below
    int    items_sent      = 0;
    char_t card_text[$];

    card_number_validator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_verdict   (o_verdict),
        .o_card_kind (o_card_kind)
    );

    always #2 i_clk = ~i_clk;

    // Receiver: drive stall on the falling edge. A requested hold-off wins over
    // random stalling and is counted down here, by one at each falling edge.
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            i_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end else if (quiet) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < 37);
        end
    end

    // Sample every accepted result on the rising edge and compare it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_verdict, o_card_kind);
        end
    end

    // Offer one item, idling first at random; hold the payload until accepted
    // and note it with the scoreboard at the accepting edge.
    task automatic send_item(input char_t ch, input logic fin);
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < 37) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= ch;
        i_last_char <= fin;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        sb.note_char(ch, fin);
        items_sent++;
    endtask

    // Send the whole text buffer, flagging its final character.
    task automatic send_card_text();
        foreach (card_text[i]) begin
            send_item(card_text[i], i == card_text.size() - 1);
        end
    endtask

    task automatic send_string(input string s);
        card_text.delete();
        for (int i = 0; i < s.len(); i++) begin
            card_text.push_back(s[i]);
        end
        send_card_text();
    endtask

    // Drop valid and wait until every predicted verdict has come back.
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic char_t pick_blank();
        case ($urandom_range(5))
            0: return 8'h20;
            1: return 8'h09;
            2: return 8'h0A;
            3: return 8'h0B;
            4: return 8'h0C;
            default: return 8'h0D;
        endcase
    endfunction

    // Build one random card text: mostly plausible numbers, a share of them
    // with a correct check digit, plus blanks, stray characters and noise.
    task automatic compose_card_text();
        int         len;
        int         sel;
        int         s;
        int         twice;
        int         spot;
        char_t      junk;
        logic [3:0] dg[$];
        card_text.delete();
        sel = $urandom_range(99);
        if (sel < 8) begin
            // raw byte noise, any value
            len = $urandom_range(1, 6);
            repeat (len) card_text.push_back(char_t'($urandom_range(255)));
            return;
        end
        sel = $urandom_range(99);
        if (sel < 80) begin
            len = $urandom_range(13, 19);
        end else if (sel < 92) begin
            len = $urandom_range(0, 12);
        end else begin
            len = $urandom_range(20, 40);  // reach past count saturation
        end
        for (int i = 0; i < len; i++) begin
            if (i == 0 && $urandom_range(9) < 6) begin
                dg.push_back(4'($urandom_range(3, 6)));
            end else if (i == 1 && $urandom_range(3) == 0) begin
                dg.push_back($urandom_range(1) ? 4'd4 : 4'd7);
            end else begin
                dg.push_back(4'($urandom_range(9)));
            end
        end
        // Fix the check digit so the Luhn sum closes: rightmost digit undoubled.
        if (len > 0 && $urandom_range(1)) begin
            s = 0;
            for (int i = 0; i < len - 1; i++) begin
                if ((i % 2) == (len % 2)) begin
                    twice = 2 * int'(dg[i]);
                    s += (twice > 9) ? twice - 9 : twice;
                end else begin
                    s += int'(dg[i]);
                end
            end
            dg[len - 1] = 4'((10 - (s % 10)) % 10);
        end
        foreach (dg[i]) begin
            if ($urandom_range(9) == 0) begin
                card_text.push_back(pick_blank());
            end
            card_text.push_back(8'h30 + char_t'(dg[i]));
        end
        if ($urandom_range(99) < 6) begin
            // stray non-digit, never a blank
            do begin
                junk = char_t'($urandom_range(255));
            end while ((junk >= 8'h30 && junk <= 8'h39) || junk == 8'h20 ||
                       (junk >= 8'h09 && junk <= 8'h0D));
            spot = $urandom_range(card_text.size());
            card_text.insert(spot, junk);
        end
        if ($urandom_range(9) == 0 || card_text.size() == 0) begin
            card_text.push_back(pick_blank());
        end
    endtask

    initial begin
        bit hold_done;
        bit pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: blank alone as the final character (no digits, kind other).
        card_text = {8'h20};
        send_card_text();
        // Lone '3' reads as JCB; '3','7' as AmericanExpress.
        send_string("3");
        send_string("37");
        // Trailing tab is skipped but still closes the number.
        send_string("6\t");
        // Byte extremes flag a non-digit.
        card_text = {8'hFF, 8'h00, 8'h35};
        send_card_text();
        // Characters just outside the digit range.
        send_string("4 0/:");
        // Shortest legal length with a passing sum.
        send_string("0000000000000");
        drain_results();

        // Random part, with a quiet stretch, one long receiver hold-off and
        // one sender pause until everything has come back.
        while (items_sent < 1900) begin
            quiet = (items_sent >= 700 && items_sent < 1000);
            if (!hold_done && items_sent >= 400) begin
                hold_off_cycles = 300;
                hold_done = 1'b1;
            end
            if (!pause_done && items_sent >= 1300) begin
                drain_results();
                pause_done = 1'b1;
            end
            compose_card_text();
            send_card_text();
        end
        quiet = 1'b0;

        drain_results();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legitimate run.
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
